/* sv/lrdc_pkg.sv */
package lrdc_pkg;

  localparam int unsigned LenW  = 24;
  localparam int unsigned CrcW  = 32;
  localparam logic [CrcW-1:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [CrcW-1:0] CrcInit = 32'hFFFF_FFFF;

  localparam logic [LenW-1:0] MaxKeyLenRst = 24'd4096;
  localparam logic [LenW-1:0] MaxValLenRst = 24'd1048576;

  localparam logic [2:0] TypeMin = 3'd1;
  localparam logic [2:0] TypeMax = 3'd4;

  typedef enum logic [2:0] {
    PH_TYPE = 3'd0,
    PH_KLEN = 3'd1,
    PH_KEY  = 3'd2,
    PH_VLEN = 3'd3,
    PH_VAL  = 3'd4,
    PH_CRC  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ROLE_FRAME = 2'd0,
    ROLE_KEY   = 2'd1,
    ROLE_VALUE = 2'd2,
    ROLE_NONE  = 2'd3
  } role_t;

  typedef enum logic [3:0] {
    ST_BUSY      = 4'd0,
    ST_VALID     = 4'd1,
    ST_BAD_TYPE  = 4'd2,
    ST_KEY_LONG  = 4'd3,
    ST_VAL_LONG  = 4'd4,
    ST_CRC_BAD   = 4'd5,
    ST_TRUNCATED = 4'd6,
    ST_END       = 4'd7,
    ST_HALTED    = 4'd8
  } status_t;

  typedef enum logic [0:0] {
    REG_MAX_KEY = 1'b0,
    REG_MAX_VAL = 1'b1
  } cfg_reg_t;

  // reflected crc-32, one byte, bit by bit
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc_in,
                                               input logic [7:0] b);
    logic [CrcW-1:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* sv/log_record_deframer_crc32_check_unit.sv */
// Splits a byte stream into length-prefixed records (type byte 1..4, 32-bit LE key
// length, key, 32-bit LE value length, value, 32-bit LE CRC-32 over the record) and
// returns one result per input transaction: the byte, its role, the record type and a
// status. Each transaction passes through an input register and a result register;
// one byte per clock is sustained unless out_ready stalls the output. The byte-wide
// CRC update and the length compare sit between those two registers. Any error or a
// clean end of stream halts the block until reset. The user must write the length limits
// through the cfg port only while no transaction is in flight; the block does not check.
module log_record_deframer_crc32_check_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_byte,
  input  logic                    in_stream_end,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              out_data_byte,
  output logic [1:0]              out_byte_role,
  output logic [2:0]              out_record_type,
  output logic [3:0]              out_status,
  output logic                    out_record_end,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [lrdc_pkg::LenW-1:0] cfg_wdata
);
  import lrdc_pkg::*;

  // configuration
  logic [LenW-1:0] max_key_r, max_val_r;

  // input stage
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;

  // deframer state
  phase_t          phase_r, phase_nxt;
  logic [1:0]      lbc_r, lbc_nxt;
  logic [31:0]     acc_r, acc_nxt;
  logic [LenW-1:0] rem_r, rem_nxt;
  logic [CrcW-1:0] crc_r, crc_nxt;
  logic [CrcW-1:0] stored_r, stored_nxt;
  logic [2:0]      type_r, type_nxt;
  logic            halted_r, halted_nxt;

  // result register
  logic       out_valid_r;
  logic [7:0] data_r, data_nxt;
  role_t      role_r, role_nxt;
  logic [2:0] rtype_r, rtype_nxt;
  status_t    status_r, status_nxt;
  logic       rend_r, rend_nxt;

  logic s1_adv;
  logic [31:0] byte_shifted;
  logic [31:0] acc_or;
  logic [31:0] stored_or;
  logic [31:0] limit;
  logic [CrcW-1:0] crc_upd;
  logic is_key;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_key_r <= MaxKeyLenRst;
      max_val_r <= MaxValLenRst;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_KEY: max_key_r <= cfg_wdata;
        REG_MAX_VAL: max_val_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_byte;
      s1_end_r  <= in_stream_end;
    end
  end

  always_comb begin
    case (lbc_r)
      2'd0:    byte_shifted = {24'd0, s1_byte_r};
      2'd1:    byte_shifted = {16'd0, s1_byte_r, 8'd0};
      2'd2:    byte_shifted = {8'd0, s1_byte_r, 16'd0};
      default: byte_shifted = {s1_byte_r, 24'd0};
    endcase
  end

  assign acc_or    = acc_r | byte_shifted;
  assign stored_or = stored_r | byte_shifted;
  assign crc_upd   = crc_byte(crc_r, s1_byte_r);
  assign is_key    = (phase_r == PH_KLEN) || (phase_r == PH_KEY);
  assign limit     = {8'd0, (is_key ? max_key_r : max_val_r)};

  always_comb begin
    phase_nxt  = phase_r;
    lbc_nxt    = lbc_r;
    acc_nxt    = acc_r;
    rem_nxt    = rem_r;
    crc_nxt    = crc_r;
    stored_nxt = stored_r;
    type_nxt   = type_r;
    halted_nxt = halted_r;
    data_nxt   = s1_byte_r;
    role_nxt   = ROLE_FRAME;
    rtype_nxt  = type_r;
    status_nxt = ST_BUSY;
    rend_nxt   = 1'b0;
    if (halted_r) begin
      data_nxt   = 8'd0;
      role_nxt   = ROLE_NONE;
      rtype_nxt  = 3'd0;
      status_nxt = ST_HALTED;
    end else if (s1_end_r) begin
      halted_nxt = 1'b1;
      data_nxt   = 8'd0;
      role_nxt   = ROLE_NONE;
      if (phase_r == PH_TYPE) begin
        rtype_nxt  = 3'd0;
        status_nxt = ST_END;
      end else begin
        status_nxt = ST_TRUNCATED;
        rend_nxt   = 1'b1;
      end
    end else begin
      case (phase_r)
        PH_TYPE: begin
          if (s1_byte_r < {5'd0, TypeMin} || s1_byte_r > {5'd0, TypeMax}) begin
            halted_nxt = 1'b1;
            rtype_nxt  = 3'd0;
            status_nxt = ST_BAD_TYPE;
            rend_nxt   = 1'b1;
          end else begin
            type_nxt   = s1_byte_r[2:0];
            rtype_nxt  = s1_byte_r[2:0];
            crc_nxt    = crc_byte(CrcInit, s1_byte_r);
            stored_nxt = '0;
            acc_nxt    = '0;
            lbc_nxt    = 2'd0;
            phase_nxt  = PH_KLEN;
          end
        end
        PH_KLEN, PH_VLEN: begin
          crc_nxt = crc_upd;
          acc_nxt = acc_or;
          if (lbc_r != 2'd3) begin
            lbc_nxt = lbc_r + 2'd1;
          end else begin
            lbc_nxt = 2'd0;
            if (acc_or > limit) begin
              halted_nxt = 1'b1;
              status_nxt = is_key ? ST_KEY_LONG : ST_VAL_LONG;
              rend_nxt   = 1'b1;
            end else begin
              rem_nxt = acc_or[LenW-1:0];
              acc_nxt = '0;
              if (acc_or[LenW-1:0] != '0) begin
                phase_nxt = is_key ? PH_KEY : PH_VAL;
              end else begin
                phase_nxt = is_key ? PH_VLEN : PH_CRC;
              end
            end
          end
        end
        PH_KEY, PH_VAL: begin
          crc_nxt  = crc_upd;
          rem_nxt  = rem_r - {{(LenW-1){1'b0}}, 1'b1};
          role_nxt = is_key ? ROLE_KEY : ROLE_VALUE;
          if (rem_r == {{(LenW-1){1'b0}}, 1'b1}) begin
            phase_nxt = is_key ? PH_VLEN : PH_CRC;
          end
        end
        PH_CRC: begin
          stored_nxt = stored_or;
          if (lbc_r != 2'd3) begin
            lbc_nxt = lbc_r + 2'd1;
          end else begin
            lbc_nxt  = 2'd0;
            rend_nxt = 1'b1;
            if (stored_or == ~crc_r) begin
              status_nxt = ST_VALID;
              phase_nxt  = PH_TYPE;
              type_nxt   = 3'd0;
              stored_nxt = '0;
              crc_nxt    = CrcInit;
            end else begin
              halted_nxt = 1'b1;
              status_nxt = ST_CRC_BAD;
            end
          end
        end
        default: begin
          phase_nxt = PH_TYPE;
          rtype_nxt = 3'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TYPE;
      lbc_r    <= 2'd0;
      acc_r    <= '0;
      rem_r    <= '0;
      crc_r    <= CrcInit;
      stored_r <= '0;
      type_r   <= 3'd0;
      halted_r <= 1'b0;
    end else if (s1_adv) begin
      phase_r  <= phase_nxt;
      lbc_r    <= lbc_nxt;
      acc_r    <= acc_nxt;
      rem_r    <= rem_nxt;
      crc_r    <= crc_nxt;
      stored_r <= stored_nxt;
      type_r   <= type_nxt;
      halted_r <= halted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      data_r   <= data_nxt;
      role_r   <= role_nxt;
      rtype_r  <= rtype_nxt;
      status_r <= status_nxt;
      rend_r   <= rend_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data_byte   = data_r;
  assign out_byte_role   = role_r;
  assign out_record_type = rtype_r;
  assign out_status      = status_r;
  assign out_record_end  = rend_r;

endmodule
